// ===== sv/mtfl_pkg.sv =====
// Package for the move-to-front key list: operation, status and cell codes,
// the cell control struct and the default sizes.
// Depends on nothing; every other file of the block uses it.
package mtfl_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned KEY_WIDTH_DEF = 8;
  localparam int unsigned OP_WIDTH      = 2;
  localparam int unsigned STATUS_WIDTH  = 3;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_INSERT  = 2'd0,
    OP_LIST    = 2'd1,
    OP_PROMOTE = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_AT_FRONT  = 3'd3,
    STS_FULL      = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  typedef enum logic [2:0] {
    CM_HOLD    = 3'd0,
    CM_INSERT  = 3'd1,
    CM_PROMOTE = 3'd2,
    CM_REMOVE  = 3'd3,
    CM_ROTATE  = 3'd4
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       commit;
  } cell_ctl_t;

endpackage

// ===== sv/mtfl_in_if.sv =====
// Request channel of the move-to-front key list: valid, ready and one item
// holding an operation and a key. Depends on mtfl_pkg.
interface mtfl_in_if #(
  parameter int unsigned KEY_WIDTH = mtfl_pkg::KEY_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [mtfl_pkg::OP_WIDTH-1:0] op;
  logic [KEY_WIDTH-1:0]          key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

// ===== sv/mtfl_out_if.sv =====
// Result channel of the move-to-front key list: valid, ready and one item
// holding status, key, entry count and last flag. Depends on mtfl_pkg.
interface mtfl_out_if #(
  parameter int unsigned KEY_WIDTH   = mtfl_pkg::KEY_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = $clog2(mtfl_pkg::CAPACITY_DEF + 1)
) ();
  logic                              valid;
  logic                              ready;
  logic [mtfl_pkg::STATUS_WIDTH-1:0] status;
  logic [KEY_WIDTH-1:0]              entry_key;
  logic [COUNT_WIDTH-1:0]            entry_count;
  logic                              last;

  modport source (output valid, status, entry_key, entry_count, last, input ready);
  modport sink   (input valid, status, entry_key, entry_count, last, output ready);
endinterface

// ===== sv/mtfl_cell.sv =====
// One list position: holds a key, compares it with the request key and
// takes a neighbour's key when the list shifts. Depends on mtfl_pkg.
module mtfl_cell #(
  parameter int unsigned KEY_WIDTH   = mtfl_pkg::KEY_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = $clog2(mtfl_pkg::CAPACITY_DEF + 1),
  parameter int unsigned INDEX       = 0
) (
  input  logic                  clk,
  input  mtfl_pkg::cell_ctl_t   ctl,
  input  logic [KEY_WIDTH-1:0]  req_key,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [KEY_WIDTH-1:0]  left_key,
  input  logic [KEY_WIDTH-1:0]  right_key,
  input  logic [KEY_WIDTH-1:0]  wrap_key,
  input  logic                  seen_in,
  output logic                  seen_out,
  output logic [KEY_WIDTH-1:0]  key_q
);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;
  logic                 in_use;
  logic                 is_tail;
  logic                 match;

  assign in_use   = COUNT_WIDTH'(INDEX) < count;
  assign is_tail  = COUNT_WIDTH'(INDEX + 1) == count;
  assign match    = in_use && (key_r == req_key);
  assign seen_out = seen_in | match;
  assign key_q    = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.commit) begin
      case (ctl.mode)
        mtfl_pkg::CM_INSERT: begin
          key_nxt = left_key;
        end
        mtfl_pkg::CM_PROMOTE: begin
          if (!seen_in) begin
            key_nxt = left_key;
          end
        end
        mtfl_pkg::CM_REMOVE: begin
          if (seen_out) begin
            key_nxt = right_key;
          end
        end
        mtfl_pkg::CM_ROTATE: begin
          if (is_tail) begin
            key_nxt = wrap_key;
          end else if (in_use) begin
            key_nxt = right_key;
          end
        end
        default: begin
          key_nxt = key_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== sv/move_to_front_key_list_core.sv =====
// Channel  Direction  Payload
// in_chan  sink       op, key
// out_chan source     status, entry_key, entry_count, last
//
// Insert, promote and remove: every cell compares its key with the request key at
// once and the cells that move all shift in the same cycle.
// A list item gives one result a cycle while each is taken, the row rotating by one
// position per result and back to its original order after the last; no new item is
// taken meanwhile. A result that is not yet taken holds off the next item; the next
// item is accepted in the cycle that the result leaves.
// Reset is synchronous and active low; it empties the list. Key storage is not reset.
// Top level of the move-to-front key list; uses mtfl_pkg, mtfl_in_if, mtfl_out_if
// and mtfl_cell.
module move_to_front_key_list_core #(
  parameter int unsigned CAPACITY  = mtfl_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = mtfl_pkg::KEY_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mtfl_in_if.sink    in_chan,
  mtfl_out_if.source out_chan
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  mtfl_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  mtfl_pkg::status_t   status_r, status_nxt;
  logic [KEY_WIDTH-1:0] ekey_r, ekey_nxt;
  logic [CW-1:0]       ecount_r, ecount_nxt;
  logic                last_r, last_nxt;

  mtfl_pkg::cell_ctl_t  cell_ctl;
  logic [KEY_WIDTH-1:0] key_q [CAPACITY];
  logic [CAPACITY:0]    seen;

  logic out_free;
  logic accept;
  logic found;
  logic front_match;
  logic list_done;
  mtfl_pkg::op_t op;

  assign out_free    = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == mtfl_pkg::S_IDLE) && out_free;
  assign accept      = in_chan.valid && in_chan.ready;
  assign op          = mtfl_pkg::op_t'(in_chan.op);
  assign found       = seen[CAPACITY];
  assign front_match = seen[1];
  assign list_done   = (idx_r + CW'(1)) == occ_r;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    logic [KEY_WIDTH-1:0] right_key;
    if (i == 0) begin : g_front
      assign left_key = in_chan.key;
    end else begin : g_inner_l
      assign left_key = key_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign right_key = key_q[i];
    end else begin : g_inner_r
      assign right_key = key_q[i+1];
    end
    mtfl_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .COUNT_WIDTH(CW),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .req_key  (in_chan.key),
      .count    (occ_r),
      .left_key (left_key),
      .right_key(right_key),
      .wrap_key (key_q[0]),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .key_q    (key_q[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtfl_pkg::S_IDLE: begin
        if (accept && op == mtfl_pkg::OP_LIST && occ_r > CW'(1)) begin
          state_nxt = mtfl_pkg::S_LIST;
        end
      end
      mtfl_pkg::S_LIST: begin
        if (out_free && list_done) begin
          state_nxt = mtfl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtfl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    status_nxt    = status_r;
    ekey_nxt      = ekey_r;
    ecount_nxt    = ecount_r;
    last_nxt      = last_r;
    cell_ctl      = '{mode: mtfl_pkg::CM_HOLD, commit: 1'b0};
    case (state_r)
      mtfl_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          ekey_nxt      = in_chan.key;
          ecount_nxt    = occ_r;
          status_nxt    = mtfl_pkg::STS_OK;
          case (op)
            mtfl_pkg::OP_LIST: begin
              if (occ_r == '0) begin
                status_nxt = mtfl_pkg::STS_EMPTY;
                ekey_nxt   = '0;
              end else begin
                ekey_nxt = key_q[0];
                last_nxt = occ_r == CW'(1);
                idx_nxt  = CW'(1);
                cell_ctl = '{mode: mtfl_pkg::CM_ROTATE, commit: 1'b1};
              end
            end
            mtfl_pkg::OP_INSERT: begin
              if (occ_r == CW'(CAPACITY)) begin
                status_nxt = mtfl_pkg::STS_FULL;
              end else begin
                occ_nxt    = occ_r + CW'(1);
                ecount_nxt = occ_r + CW'(1);
                cell_ctl   = '{mode: mtfl_pkg::CM_INSERT, commit: 1'b1};
              end
            end
            default: begin
              if (occ_r == '0) begin
                status_nxt = mtfl_pkg::STS_EMPTY;
              end else if (!found) begin
                status_nxt = mtfl_pkg::STS_NOT_FOUND;
              end else if (op == mtfl_pkg::OP_PROMOTE) begin
                if (front_match) begin
                  status_nxt = mtfl_pkg::STS_AT_FRONT;
                end else begin
                  cell_ctl = '{mode: mtfl_pkg::CM_PROMOTE, commit: 1'b1};
                end
              end else begin
                occ_nxt    = occ_r - CW'(1);
                ecount_nxt = occ_r - CW'(1);
                cell_ctl   = '{mode: mtfl_pkg::CM_REMOVE, commit: 1'b1};
              end
            end
          endcase
        end
      end
      mtfl_pkg::S_LIST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = mtfl_pkg::STS_OK;
          ekey_nxt      = key_q[0];
          ecount_nxt    = occ_r;
          last_nxt      = list_done;
          idx_nxt       = idx_r + CW'(1);
          cell_ctl      = '{mode: mtfl_pkg::CM_ROTATE, commit: 1'b1};
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_chan.ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtfl_pkg::S_IDLE;
      occ_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    ekey_r   <= ekey_nxt;
    ecount_r <= ecount_nxt;
    last_r   <= last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.entry_key   = ekey_r;
  assign out_chan.entry_count = ecount_r;
  assign out_chan.last        = last_r;

endmodule

// ===== sv/mtfl_checker.sv =====
// Port-level checks on the results of the move-to-front key list, with the bind
// that attaches them to move_to_front_key_list_core. Depends on mtfl_pkg.
module mtfl_checker #(
  parameter int unsigned CAPACITY  = mtfl_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = mtfl_pkg::KEY_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mtfl_pkg::STATUS_WIDTH-1:0] out_status,
  input logic [KEY_WIDTH-1:0]              out_entry_key,
  input logic [$clog2(CAPACITY + 1)-1:0]   out_entry_count,
  input logic                              out_last
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry_key) && $stable(out_entry_count) && $stable(out_last))
    else $error("A stalled result item changed.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CW'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mtfl_pkg::STS_EMPTY |-> out_entry_count == '0 && out_last)
    else $error("An empty-list result reports entries.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mtfl_pkg::STS_FULL |-> out_entry_count == CW'(CAPACITY))
    else $error("A full result reports a list that is not full.");

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mtfl_pkg::STS_OK |-> out_last)
    else $error("A failed operation gave more than one result item.");

endmodule

bind move_to_front_key_list_core mtfl_checker #(
  .CAPACITY (CAPACITY),
  .KEY_WIDTH(KEY_WIDTH)
) u_mtfl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_entry_key  (out_chan.entry_key),
  .out_entry_count(out_chan.entry_count),
  .out_last       (out_chan.last)
);
